/* rtl/rcwc_pkg.sv */
// rcwc_pkg: shared widths, codes, reset values and types for the ring cache window control block
// no dependencies; used by the interfaces, the modulo unit, the core and the checker
`timescale 1ns / 1ps

package rcwc_pkg;

	localparam int BYTES_W    = 25;
	localparam int RING_IDX_W = 24;
	localparam int STREAM_W   = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int FRESH_W    = 31;

	localparam int DEF_POS_BITS       = 32;
	localparam int DEF_MAX_FILL_CHUNK = 32768;

	localparam logic [BYTES_W-1:0] RING_LIMIT = 25'd16777216;
	localparam logic [FRESH_W-1:0] NEWB_CAP   = 31'd1073741824;

	localparam logic [BYTES_W-1:0] RST_BUFFER_BYTES   = 25'd1048576;
	localparam logic [BYTES_W-1:0] RST_LOOKBACK_BYTES = 25'd524288;
	localparam logic [BYTES_W-1:0] RST_FILL_THRESHOLD = 25'd16384;

	typedef enum logic {
		MODE_READ = 1'b0,
		MODE_FILL = 1'b1
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUFFER_BYTES   = 2'd0,
		REG_LOOKBACK_BYTES = 2'd1,
		REG_FILL_THRESHOLD = 2'd2
	} reg_idx_t;

	// status of the multi-cycle modulo unit
	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

endpackage

/* rtl/rcwc_ifs.sv */
// rcwc_ifs: valid/ready channel interfaces for requests, results and register writes
// depends on rcwc_pkg for field widths
`timescale 1ns / 1ps

interface rcwc_req_if;
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic [rcwc_pkg::BYTES_W-1:0] request_bytes;

	modport source (output valid, mode, request_bytes, input ready);
	modport sink (input valid, mode, request_bytes, output ready);
endinterface

interface rcwc_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [rcwc_pkg::BYTES_W-1:0]    grant_bytes;
	logic [rcwc_pkg::RING_IDX_W-1:0] ring_index;
	logic [rcwc_pkg::STREAM_W-1:0]   stream_pos;
	logic                            stalled;

	modport source (output valid, grant_bytes, ring_index, stream_pos, stalled, input ready);
	modport sink (input valid, grant_bytes, ring_index, stream_pos, stalled, output ready);
endinterface

interface rcwc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rcwc_pkg::CFG_IDX_W-1:0] index;
	logic [rcwc_pkg::BYTES_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/rcwc_mod.sv */
// rcwc_mod: bit-serial restoring modulo unit, one dividend bit per cycle
// depends on rcwc_pkg for the divisor width and the status struct
`timescale 1ns / 1ps

module rcwc_mod #(
	parameter int PW = rcwc_pkg::DEF_POS_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [PW-1:0]                dividend,
	input  logic [rcwc_pkg::BYTES_W-1:0] divisor,
	output rcwc_pkg::mod_stat_t          stat,
	output logic [rcwc_pkg::BYTES_W-1:0] rem
);

	localparam int CNT_W = (PW > 1) ? $clog2(PW) : 1;

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [PW-1:0]                dvd_q;
	logic [rcwc_pkg::BYTES_W-1:0] div_q;
	logic [rcwc_pkg::BYTES_W-1:0] rem_q;
	logic [rcwc_pkg::BYTES_W:0]   trial;
	logic [rcwc_pkg::BYTES_W:0]   div_e;

	assign trial = {rem_q, dvd_q[PW-1]};
	assign div_e = {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			// remainder stays below the divisor, so the trial fits one extra bit
			if (trial >= div_e) begin
				rem_q <= rcwc_pkg::BYTES_W'(trial - div_e);
			end else begin
				rem_q <= trial[rcwc_pkg::BYTES_W-1:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

endmodule

/* rtl/ring_cache_window_control_core.sv */
// ring_cache_window_control_core: pointer controller for a circular stream cache
// result path: the request transfer goes to the input register, then to the result register
// throughput: one request per cycle while results are taken and the start position lies
//   from one ring size below base to under two ring sizes above it; otherwise a request
//   waits for the modulo unit; reset: arst_n clears all pointers to zero and loads register defaults
// depends on rcwc_pkg, rcwc_ifs and rcwc_mod
`timescale 1ns / 1ps

module ring_cache_window_control_core #(
	parameter int POS_BITS       = rcwc_pkg::DEF_POS_BITS,
	parameter int MAX_FILL_CHUNK = rcwc_pkg::DEF_MAX_FILL_CHUNK
) (
	input logic      clk,
	input logic      arst_n,
	rcwc_req_if.sink req,
	rcwc_rsp_if.source rsp,
	rcwc_cfg_if.sink cfg
);

	localparam int P  = POS_BITS;
	localparam int EW = (P > 26) ? P : 26;
	localparam int CW = (P > 32) ? P : 32;
	localparam int XW = (P > 31) ? P : 31;
	localparam int BW = rcwc_pkg::BYTES_W;
	localparam logic [BW-1:0] MAXC = BW'(MAX_FILL_CHUNK);

	// configuration
	logic [BW-1:0] buffer_q;
	logic [BW-1:0] lookback_q;
	logic [BW-1:0] threshold_q;

	// pointer state
	logic [P-1:0] reader_q;
	logic [P-1:0] oldest_q;
	logic [P-1:0] newest_q;
	logic [P-1:0] base_q;

	// input stage
	logic          valid_s1;
	logic          mode_s1;
	logic [BW-1:0] req_s1;

	// result register
	logic                            rsp_valid_q;
	logic [BW-1:0]                   grant_q;
	logic [rcwc_pkg::RING_IDX_W-1:0] index_q;
	logic [rcwc_pkg::STREAM_W-1:0]   spos_q;
	logic                            stall_q;

	logic                mod_ready_q;
	rcwc_pkg::mod_stat_t mod_stat;
	logic [BW-1:0]       mod_rem;
	logic                mod_start;

	logic          is_fill;
	logic [BW-1:0] ring;
	logic [P-1:0]  place_src;
	logic [P-1:0]  pd;
	logic          pneg;
	logic [P-1:0]  pmag;
	logic [EW-1:0] pmag_e;
	logic [EW-1:0] ring_e;
	logic          fast_ok;
	logic [BW-1:0] place_fast;
	logic [BW-1:0] place_slow;
	logic [BW-1:0] place;
	logic [BW-1:0] ring_left;

	logic [P-1:0]  dn;
	logic [P-1:0]  db;
	logic [BW-1:0] rd_g1;
	logic [BW-1:0] rd_grant;
	logic          rd_stall;

	logic [BW-1:0]                back;
	logic [rcwc_pkg::FRESH_W-1:0] fresh;
	logic [31:0]                  used;
	logic signed [33:0]           space;
	logic                         refuse;
	logic [BW-1:0]                fl_g1;
	logic [BW-1:0]                fl_grant;
	logic                         wrap;

	logic [BW-1:0] grant;
	logic          stall;
	logic [P-1:0]  start_pos;
	logic [XW-1:0] start_x;
	logic          go;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_q    <= rcwc_pkg::RST_BUFFER_BYTES;
			lookback_q  <= rcwc_pkg::RST_LOOKBACK_BYTES;
			threshold_q <= rcwc_pkg::RST_FILL_THRESHOLD;
		end else if (cfg.valid) begin
			case (cfg.index)
				rcwc_pkg::REG_BUFFER_BYTES:   buffer_q    <= cfg.data;
				rcwc_pkg::REG_LOOKBACK_BYTES: lookback_q  <= cfg.data;
				rcwc_pkg::REG_FILL_THRESHOLD: threshold_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// effective ring size: zero acts as one, clipped to the ring limit
	always_comb begin
		if (buffer_q == '0) begin
			ring = BW'(1);
		end else if (buffer_q > rcwc_pkg::RING_LIMIT) begin
			ring = rcwc_pkg::RING_LIMIT;
		end else begin
			ring = buffer_q;
		end
	end

	assign is_fill   = (mode_s1 == rcwc_pkg::MODE_FILL);
	assign place_src = is_fill ? newest_q : reader_q;
	assign pd        = place_src - base_q;
	assign pneg      = pd[P-1];
	assign pmag      = pneg ? (~pd + P'(1)) : pd;
	assign pmag_e    = EW'(pmag);
	assign ring_e    = EW'(ring);

	// ring position: one correction step here, the modulo unit otherwise
	always_comb begin
		fast_ok    = 1'b1;
		place_fast = '0;
		if (pneg) begin
			if (pmag_e <= ring_e) begin
				place_fast = BW'(ring_e - pmag_e);
			end else begin
				fast_ok = 1'b0;
			end
		end else if (pmag_e < ring_e) begin
			place_fast = BW'(pmag_e);
		end else if (pmag_e < (ring_e << 1)) begin
			place_fast = BW'(pmag_e - ring_e);
		end else begin
			fast_ok = 1'b0;
		end
	end

	assign place_slow = pneg ? ((mod_rem == '0) ? '0 : (ring - mod_rem)) : mod_rem;
	assign place      = fast_ok ? place_fast : place_slow;
	assign ring_left  = ring - place;

	assign dn = newest_q - reader_q;
	assign db = reader_q - oldest_q;

	// read: cached bytes, clipped to ring end and request
	always_comb begin
		rd_stall = dn[P-1] || (dn == '0);
		rd_g1    = (CW'(dn) < CW'(ring_left)) ? BW'(dn) : ring_left;
		rd_grant = (req_s1 < rd_g1) ? req_s1 : rd_g1;
		if (rd_stall) begin
			rd_grant = '0;
		end
	end

	// fill: free space after keeping look-back and unread bytes, clipped to ring end and chunk size
	always_comb begin
		if (db[P-1]) begin
			back = '0;
		end else if (CW'(db) > CW'(lookback_q)) begin
			back = lookback_q;
		end else begin
			back = BW'(db);
		end
		if (dn[P-1]) begin
			fresh = '0;
		end else if (CW'(dn) > CW'(rcwc_pkg::NEWB_CAP)) begin
			fresh = rcwc_pkg::NEWB_CAP;
		end else begin
			fresh = rcwc_pkg::FRESH_W'(dn);
		end
		used   = 32'(fresh) + 32'(back);
		space  = $signed({9'b0, ring}) - $signed({2'b0, used});
		refuse = space < $signed({9'b0, threshold_q});
		fl_g1  = (space[BW-1:0] < ring_left) ? space[BW-1:0] : ring_left;
		fl_grant = (fl_g1 > MAXC) ? MAXC : fl_g1;
		if (refuse) begin
			fl_grant = '0;
		end
		wrap = ({1'b0, place} + {1'b0, fl_grant}) >= {1'b0, ring};
	end

	assign grant     = is_fill ? fl_grant : rd_grant;
	assign stall     = is_fill ? (refuse || (fl_grant == '0)) : rd_stall;
	assign start_pos = place_src;
	assign start_x   = XW'(start_pos);

	// no restart in the done cycle, so the remainder holds until the result is taken
	assign go        = valid_s1 && (fast_ok || mod_ready_q) && (!rsp_valid_q || rsp.ready);
	assign mod_start = valid_s1 && !fast_ok && !mod_ready_q && !mod_stat.busy
		&& !mod_stat.done;
	assign req.ready = !valid_s1 || go;

	rcwc_mod #(
		.PW(P)
	) u_rcwc_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (pmag),
		.divisor  (ring),
		.stat     (mod_stat),
		.rem      (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			mod_ready_q <= 1'b0;
			reader_q    <= '0;
			oldest_q    <= '0;
			newest_q    <= '0;
			base_q      <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (go) begin
				mod_ready_q <= 1'b0;
			end else if (mod_stat.done) begin
				mod_ready_q <= 1'b1;
			end
			if (go) begin
				if (!is_fill) begin
					reader_q <= reader_q + P'(rd_grant);
				end else if (!refuse) begin
					oldest_q <= reader_q - P'(back);
					newest_q <= newest_q + P'(fl_grant);
					if (wrap) begin
						base_q <= base_q + P'(ring);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_s1 <= req.mode;
			req_s1  <= req.request_bytes;
		end
		if (go) begin
			grant_q <= grant;
			index_q <= place[rcwc_pkg::RING_IDX_W-1:0];
			spos_q  <= start_x[rcwc_pkg::STREAM_W-1:0];
			stall_q <= stall;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.grant_bytes = grant_q;
	assign rsp.ring_index  = index_q;
	assign rsp.stream_pos  = spos_q;
	assign rsp.stalled     = stall_q;

endmodule

/* rtl/rcwc_checker.sv */
// rcwc_checker: port-level assertions for ring_cache_window_control_core, with its bind
// depends on rcwc_pkg for widths and the ring limit
`timescale 1ns / 1ps

module rcwc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [rcwc_pkg::BYTES_W-1:0]    grant_bytes,
	input logic [rcwc_pkg::RING_IDX_W-1:0] ring_index,
	input logic                            stalled
);

	// a held result keeps its grant
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(grant_bytes))
		else $error("result changed while waiting for transfer");

	// a stall never grants bytes
	a_stall_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && stalled |-> grant_bytes == '0)
		else $error("stalled result with nonzero grant");

	// a granted chunk never runs past the ring limit
	a_no_cross: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ({1'b0, 1'b0, ring_index} + {1'b0, grant_bytes})
			<= {1'b0, rcwc_pkg::RING_LIMIT})
		else $error("chunk crosses ring end");

	// nothing is shown right after reset
	a_rst_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid)
		else $error("result valid out of reset");

endmodule

bind ring_cache_window_control_core rcwc_checker u_rcwc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.grant_bytes (rsp.grant_bytes),
	.ring_index  (rsp.ring_index),
	.stalled     (rsp.stalled)
);

/* sim/tb_ring_cache_window_control_core.sv */
// tb_ring_cache_window_control_core: self-checking bench for the ring cache window controller
// directed table then random read/fill phases under several register settings, checked
// against known values or an in-bench pointer predictor; depends on rcwc_pkg, rcwc_ifs and the core
`timescale 1ns / 1ps

module tb_ring_cache_window_control_core;
	import rcwc_pkg::*;

	localparam int PB            = DEF_POS_BITS;
	localparam int SETTLE_CYCLES = DEF_POS_BITS + 6;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 144;
	localparam logic [BYTES_W-1:0] FULL_REQ = 25'd16777216;

	typedef struct packed {
		logic [BYTES_W-1:0]    grant_bytes;
		logic [RING_IDX_W-1:0] ring_index;
		logic [STREAM_W-1:0]   stream_pos;
		logic                  stalled;
	} grant_t;

	typedef enum logic [1:0] {
		STEP_REQ,
		STEP_REQ_KNOWN,
		STEP_REG
	} step_kind_t;

	typedef struct packed {
		step_kind_t         kind;
		mode_t              mode;
		reg_idx_t           ridx;
		logic [BYTES_W-1:0] value;
		grant_t             known;
	} step_t;

	logic clk;
	logic arst_n;

	rcwc_req_if req_ch();
	rcwc_rsp_if rsp_ch();
	rcwc_cfg_if cfg_ch();

	ring_cache_window_control_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// predictor copy of the register file and pointer state
	logic [BYTES_W-1:0] ring_cfg, keep_cfg, thresh_cfg;
	logic [PB-1:0]      rd_pos, old_pos, new_pos, base_pos;

	grant_t pending_grants[$];
	step_t  directed_steps[$];
	grant_t due_grant;

	int unsigned errors = 0;
	int unsigned reads_sent = 0;
	int unsigned fills_sent = 0;
	int unsigned reg_writes = 0;
	int unsigned results_checked = 0;
	int unsigned stalls_seen = 0;
	int unsigned wraps = 0;
	int unsigned cycle_count = 0;
	bit          steady_send = 1'b0;
	bit          steady_take = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// magnitude of a - b read as a signed position difference
	function automatic longint unsigned pos_delta(input logic [PB-1:0] a, input logic [PB-1:0] b,
			output bit neg);
		logic [PB-1:0] d;
		d = a - b;
		neg = d[PB-1];
		if (neg)
			d = ~d + 1'b1;
		return d;
	endfunction

	function automatic longint unsigned ring_offset(input logic [PB-1:0] a, input logic [PB-1:0] b,
			input longint unsigned ring);
		longint unsigned m, r;
		bit neg;
		m = pos_delta(a, b, neg);
		if (neg) begin
			if (m <= ring)
				return ring - m;
			r = m % ring;
			return (r != 0) ? ring - r : 0;
		end
		if (m < ring)
			return m;
		if (m - ring < ring)
			return m - ring;
		return m % ring;
	endfunction

	function automatic longint unsigned live_ring();
		if (ring_cfg == 0)
			return 1;
		if (ring_cfg > RING_LIMIT)
			return RING_LIMIT;
		return ring_cfg;
	endfunction

	function automatic grant_t predict_grant(input mode_t m, input logic [BYTES_W-1:0] want);
		grant_t g;
		longint unsigned ring, place, amount, back, fresh;
		longint space;
		bit neg;
		logic [PB-1:0] start;
		ring = live_ring();
		amount = 0;
		if (m == MODE_READ) begin
			place = ring_offset(rd_pos, base_pos, ring);
			start = rd_pos;
			fresh = pos_delta(new_pos, rd_pos, neg);
			if (neg || fresh == 0) begin
				g.stalled = 1'b1;
			end else begin
				amount = fresh;
				if (amount > ring - place)
					amount = ring - place;
				if (amount > want)
					amount = want;
				rd_pos = rd_pos + amount[PB-1:0];
				g.stalled = 1'b0;
			end
		end else begin
			back = pos_delta(rd_pos, old_pos, neg);
			if (neg)
				back = 0;
			else if (back > keep_cfg)
				back = keep_cfg;
			fresh = pos_delta(new_pos, rd_pos, neg);
			if (neg)
				fresh = 0;
			else if (fresh > NEWB_CAP)
				fresh = NEWB_CAP;
			space = longint'(ring) - longint'(fresh + back);
			place = ring_offset(new_pos, base_pos, ring);
			start = new_pos;
			if (space < longint'(thresh_cfg)) begin
				g.stalled = 1'b1;
			end else begin
				amount = space;
				if (amount > ring - place)
					amount = ring - place;
				if (amount > DEF_MAX_FILL_CHUNK)
					amount = DEF_MAX_FILL_CHUNK;
				old_pos = rd_pos - back[PB-1:0];
				new_pos = new_pos + amount[PB-1:0];
				// fill reaching the ring end moves the file-to-ring offset
				if (place + amount >= ring) begin
					base_pos = base_pos + ring[PB-1:0];
					wraps++;
				end
				g.stalled = (amount == 0);
			end
		end
		g.grant_bytes = amount[BYTES_W-1:0];
		g.ring_index = place[RING_IDX_W-1:0];
		g.stream_pos = start[STREAM_W-1:0];
		return g;
	endfunction

	function automatic logic [BYTES_W-1:0] pick_request();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return FULL_REQ;
			2, 3, 4, 5: return BYTES_W'($urandom_range(1, 64));
			6, 7: return BYTES_W'($urandom_range(1, 65536));
			default: return BYTES_W'($urandom_range(0, 16777216));
		endcase
	endfunction

	task automatic add_req(input mode_t m, input logic [BYTES_W-1:0] v);
		step_t s;
		s = '0;
		s.kind = STEP_REQ;
		s.mode = m;
		s.value = v;
		directed_steps.push_back(s);
	endtask

	task automatic add_known(input mode_t m, input logic [BYTES_W-1:0] v,
			input logic [BYTES_W-1:0] gb, input logic [RING_IDX_W-1:0] ri,
			input logic [STREAM_W-1:0] sp, input logic st);
		step_t s;
		s = '0;
		s.kind = STEP_REQ_KNOWN;
		s.mode = m;
		s.value = v;
		s.known.grant_bytes = gb;
		s.known.ring_index = ri;
		s.known.stream_pos = sp;
		s.known.stalled = st;
		directed_steps.push_back(s);
	endtask

	task automatic add_reg(input reg_idx_t r, input logic [BYTES_W-1:0] v);
		step_t s;
		s = '0;
		s.kind = STEP_REG;
		s.ridx = r;
		s.value = v;
		directed_steps.push_back(s);
	endtask

	// drop valid and wait until every expected result is back and the core has settled
	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t r, input logic [BYTES_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= r;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		case (r)
			REG_BUFFER_BYTES:   ring_cfg = v;
			REG_LOOKBACK_BYTES: keep_cfg = v;
			REG_FILL_THRESHOLD: thresh_cfg = v;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// one request transfer; the expectation is queued in the step of the transfer
	task automatic issue(input mode_t m, input logic [BYTES_W-1:0] v, input bit use_known,
			input grant_t known);
		int gap;
		grant_t g;
		gap = steady_send ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.mode <= m;
		req_ch.request_bytes <= v;
		do @(posedge clk); while (!req_ch.ready);
		g = predict_grant(m, v);
		pending_grants.push_back(use_known ? known : g);
		if (m == MODE_READ)
			reads_sent++;
		else
			fills_sent++;
	endtask

	// result side: random hold-off per result, with stretches of none
	initial begin
		int hold;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 47) == 0)
				steady_take = !steady_take;
			hold = steady_take ? 0 : $urandom_range(0, 11);
			if (hold > 0) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_grants.size() == 0) begin
				errors++;
				$display("%0t unexpected result transfer: grant_bytes %0d ring_index %0d",
					$time, rsp_ch.grant_bytes, rsp_ch.ring_index);
			end else begin
				due_grant = pending_grants.pop_front();
				results_checked++;
				if (rsp_ch.stalled)
					stalls_seen++;
				if (rsp_ch.grant_bytes !== due_grant.grant_bytes) begin
					errors++;
					$display("%0t grant_bytes mismatch: expected %0d, actual %0d",
						$time, due_grant.grant_bytes, rsp_ch.grant_bytes);
				end
				if (rsp_ch.ring_index !== due_grant.ring_index) begin
					errors++;
					$display("%0t ring_index mismatch: expected %0d, actual %0d",
						$time, due_grant.ring_index, rsp_ch.ring_index);
				end
				if (rsp_ch.stream_pos !== due_grant.stream_pos) begin
					errors++;
					$display("%0t stream_pos mismatch: expected %0d, actual %0d",
						$time, due_grant.stream_pos, rsp_ch.stream_pos);
				end
				if (rsp_ch.stalled !== due_grant.stalled) begin
					errors++;
					$display("%0t stalled mismatch: expected %0b, actual %0b",
						$time, due_grant.stalled, rsp_ch.stalled);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, pending_grants.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		step_t s;
		mode_t m;
		logic [BYTES_W-1:0] rb, lb, th;
		int burst_left;
		mode_t burst_mode;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_READ;
		req_ch.request_bytes = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_BUFFER_BYTES;
		cfg_ch.data = '0;
		ring_cfg = RST_BUFFER_BYTES;
		keep_cfg = RST_LOOKBACK_BYTES;
		thresh_cfg = RST_FILL_THRESHOLD;
		rd_pos = '0;
		old_pos = '0;
		new_pos = '0;
		base_pos = '0;
		burst_left = 0;
		burst_mode = MODE_READ;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty ring after reset, then two full chunks and reads across them
		add_known(MODE_READ, '0, '0, '0, '0, 1'b1);
		add_known(MODE_READ, FULL_REQ, '0, '0, '0, 1'b1);
		add_known(MODE_FILL, '0, 25'd32768, 24'd0, 31'd0, 1'b0);
		add_known(MODE_FILL, FULL_REQ, 25'd32768, 24'd32768, 31'd32768, 1'b0);
		add_known(MODE_READ, '0, '0, '0, '0, 1'b0);
		add_known(MODE_READ, 25'd1, 25'd1, 24'd0, 31'd0, 1'b0);
		add_known(MODE_READ, FULL_REQ, 25'd65535, 24'd1, 31'd1, 1'b0);
		add_known(MODE_READ, 25'd5, '0, 24'd65536, 31'd65536, 1'b1);
		// shrink the ring under live pointers: far-off index, zero-space fill, wrap
		add_reg(REG_LOOKBACK_BYTES, 25'd1024);
		add_reg(REG_FILL_THRESHOLD, '0);
		add_reg(REG_BUFFER_BYTES, 25'd4096);
		add_req(MODE_FILL, 25'h0AAAAAA);
		add_req(MODE_FILL, 25'h1555555);
		add_req(MODE_READ, FULL_REQ);
		add_req(MODE_FILL, '0);
		add_req(MODE_READ, 25'd100);
		// zero ring size acts as one byte
		add_reg(REG_BUFFER_BYTES, '0);
		add_req(MODE_FILL, '0);
		add_req(MODE_READ, FULL_REQ);
		add_req(MODE_READ, '0);
		// oversize ring clips to the limit; maximum threshold refuses the fill
		add_reg(REG_BUFFER_BYTES, 25'h1FFFFFF);
		add_reg(REG_FILL_THRESHOLD, FULL_REQ);
		add_req(MODE_FILL, '0);
		add_reg(REG_LOOKBACK_BYTES, FULL_REQ);
		add_reg(REG_FILL_THRESHOLD, '0);
		add_req(MODE_FILL, '0);
		add_req(MODE_READ, 25'd12345);

		foreach (directed_steps[i]) begin
			s = directed_steps[i];
			if (s.kind == STEP_REG)
				write_reg(s.ridx, s.value);
			else
				issue(s.mode, s.value, s.kind == STEP_REQ_KNOWN, s.known);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					rb = RST_BUFFER_BYTES;
					lb = RST_LOOKBACK_BYTES;
					th = RST_FILL_THRESHOLD;
				end
				1: begin
					rb = 25'd4096;
					lb = '0;
					th = '0;
				end
				2: begin
					rb = FULL_REQ;
					lb = FULL_REQ;
					th = FULL_REQ;
				end
				3: begin
					rb = '0;
					lb = BYTES_W'($urandom_range(0, 8));
					th = '0;
				end
				4: begin
					rb = BYTES_W'($urandom_range(1, 65536));
					lb = BYTES_W'($urandom_range(0, rb));
					th = BYTES_W'($urandom_range(0, rb / 4));
				end
				5: begin
					rb = 25'h1FFFFFF;
					lb = '0;
					th = 25'd32768;
				end
				6: begin
					rb = BYTES_W'($urandom_range(1, 16777216));
					lb = BYTES_W'($urandom_range(0, 16777216));
					th = BYTES_W'($urandom_range(0, 65536));
				end
				default: begin
					rb = 25'd512;
					lb = 25'd256;
					th = 25'd1;
				end
			endcase
			write_reg(REG_BUFFER_BYTES, rb);
			write_reg(REG_LOOKBACK_BYTES, lb);
			write_reg(REG_FILL_THRESHOLD, th);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// runs of reads or fills so the ring both fills up and drains
				if (burst_left == 0) begin
					burst_mode = mode_t'($urandom_range(0, 1));
					burst_left = $urandom_range(1, 12);
				end
				burst_left--;
				m = ($urandom_range(0, 7) == 0) ? mode_t'(!burst_mode) : burst_mode;
				if ($urandom_range(0, 63) == 0)
					steady_send = !steady_send;
				issue(m, (m == MODE_READ) ? pick_request()
					: BYTES_W'($urandom_range(0, 16777216)), 1'b0, '0);
			end
		end

		wait_idle();

		$display("covered %0d reads and %0d fills across %0d register writes,",
			reads_sent, fills_sent, reg_writes);
		$display("ring sizes zero to oversize; checked %0d results: %0d stalled, %0d ring wraps",
			results_checked, stalls_seen, wraps);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/rcwc_pkg.sv
rtl/rcwc_ifs.sv
rtl/rcwc_mod.sv
rtl/ring_cache_window_control_core.sv
rtl/rcwc_checker.sv
sim/tb_ring_cache_window_control_core.sv
